### hw/rtl/paids_pkg.sv
// Shared types and constants for the positional list core.
// Used by paids_cell, paids_ctrl and the top level; depends on nothing.
package paids_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned MAX_OUT  = 64;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned TYPE_W   = 2;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned FILL_W   = 7;

  // cell index, fill count, and a compare width wide enough for both and for position
  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (AW + 1 > POS_W) ? AW + 1 : POS_W;

  typedef enum logic [TYPE_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_DUMP   = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
    logic rotate;
  } cell_ctl_t;

endpackage

### hw/rtl/paids_cell.sv
// One storage cell of the list chain: holds a single entry.
// Depends on paids_pkg for widths and the cell command struct.
module paids_cell import paids_pkg::*; (
  input  logic                     clk_i,
  input  cell_ctl_t                ctl_i,
  input  logic [CMP_W-1:0]         cell_idx_i,
  input  logic [CMP_W-1:0]         pos_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic signed [DATA_W-1:0] prev_i,
  input  logic signed [DATA_W-1:0] next_i,
  output logic signed [DATA_W-1:0] data_o
);

  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     en;

  always_comb begin
    en     = 1'b1;
    data_d = data_q;
    priority if (ctl_i.insert && (cell_idx_i > pos_i)) begin
      data_d = prev_i;
    end else if (ctl_i.insert && (cell_idx_i == pos_i)) begin
      data_d = value_i;
    end else if ((ctl_i.remove && (cell_idx_i >= pos_i)) || ctl_i.rotate) begin
      data_d = next_i;
    end else begin
      en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

### hw/rtl/paids_ctrl.sv
// Sequencer and output register for the positional list core.
// Depends on paids_pkg; drives the cell chain and reads its head cell.
module paids_ctrl import paids_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [TYPE_W-1:0]        req_type_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [INDEX_W-1:0]       index_o,
  output logic signed [DATA_W-1:0] item_value_o,
  output logic [FILL_W-1:0]        fill_count_o,
  output logic                     last_o,
  input  logic signed [DATA_W-1:0] head_i,
  output cell_ctl_t                ctl_o,
  output logic [CMP_W-1:0]         pos_o
);

  localparam logic [AW-1:0]    KMAX    = AW'(CAPACITY - 1);
  localparam logic [CMP_W-1:0] CAP_C   = CMP_W'(CAPACITY);
  localparam logic [CMP_W-1:0] MAXOUT_C = CMP_W'(MAX_OUT);

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [AW-1:0]            k_q, k_d;
  req_e                     req_q, req_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     found_q, found_d;
  logic [AW-1:0]            fidx_q, fidx_d;

  logic                     out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]      status_q, status_d;
  logic [INDEX_W-1:0]       index_q, index_d;
  logic signed [DATA_W-1:0] item_q, item_d;
  logic [FILL_W-1:0]        fill_q, fill_d;
  logic                     last_q, last_d;
  logic                     load_out;

  logic             accept, can_emit, step;
  req_e             req_in;
  logic [CMP_W-1:0] count_ext, k_ext, n_ext;
  logic             in_range, hit, dump_emit, search_end, found_any;
  logic [AW-1:0]    hit_idx;

  assign req_in    = req_e'(req_type_i);
  assign pos_o     = CMP_W'(position_i);
  assign count_ext = CMP_W'(count_q);
  assign k_ext     = CMP_W'(k_q);
  assign n_ext     = (count_ext > MAXOUT_C) ? MAXOUT_C : count_ext;

  assign can_emit   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && can_emit;
  assign accept     = in_valid_i && in_ready_o;

  // head cell holds entry k during the scan rotation
  assign in_range   = k_ext < count_ext;
  assign hit        = in_range && (head_i == val_q) && !found_q;
  assign dump_emit  = (state_q == S_SCAN) && (req_q == REQ_DUMP) && (k_ext < n_ext);
  assign search_end = (state_q == S_SCAN) && (req_q == REQ_SEARCH) && (k_q == KMAX);
  assign step       = (state_q == S_SCAN) && (!(dump_emit || search_end) || can_emit);
  assign found_any  = found_q || hit;
  assign hit_idx    = found_q ? fidx_q : k_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && ((req_in == REQ_SEARCH) ||
                       ((req_in == REQ_DUMP) && (count_q != '0)))) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (step && (k_q == KMAX)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ctl_o    = '0;
    count_d  = count_q;
    k_d      = k_q;
    req_d    = req_q;
    val_d    = val_q;
    found_d  = found_q;
    fidx_d   = fidx_q;
    load_out = 1'b0;
    status_d = ST_OK;
    index_d  = '0;
    item_d   = '0;
    fill_d   = FILL_W'(count_q);
    last_d   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_in)
            REQ_INSERT: begin
              load_out = 1'b1;
              if ((pos_o > count_ext) || (count_ext >= CAP_C)) begin
                status_d = ST_INVALID;
              end else begin
                ctl_o.insert = 1'b1;
                count_d      = count_q + 1'b1;
                fill_d       = FILL_W'(count_d);
              end
            end
            REQ_DELETE: begin
              load_out = 1'b1;
              if (pos_o >= count_ext) begin
                status_d = ST_INVALID;
              end else begin
                ctl_o.remove = 1'b1;
                count_d      = count_q - 1'b1;
                fill_d       = FILL_W'(count_d);
              end
            end
            REQ_SEARCH: begin
              k_d     = '0;
              found_d = 1'b0;
              req_d   = REQ_SEARCH;
              val_d   = value_i;
            end
            REQ_DUMP: begin
              if (count_q == '0) begin
                load_out = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                k_d   = '0;
                req_d = REQ_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (step) begin
          ctl_o.rotate = 1'b1;
          k_d          = (k_q == KMAX) ? '0 : k_q + 1'b1;
          if (hit) begin
            found_d = 1'b1;
            fidx_d  = k_q;
          end
          if (dump_emit) begin
            load_out = 1'b1;
            index_d  = INDEX_W'(k_q);
            item_d   = head_i;
            last_d   = (k_ext == (n_ext - 1'b1));
          end else if (search_end) begin
            load_out = 1'b1;
            status_d = found_any ? ST_OK : ST_NOT_FOUND;
            index_d  = found_any ? INDEX_W'(hit_idx) : '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      k_q         <= k_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    val_q  <= val_d;
    fidx_q <= fidx_d;
    if (load_out) begin
      status_q <= status_d;
      index_q  <= index_d;
      item_q   <= item_d;
      fill_q   <= fill_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign index_o      = index_q;
  assign item_value_o = item_q;
  assign fill_count_o = fill_q;
  assign last_o       = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_count_only_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("fill count changed without an input transfer");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (k_q == KMAX)) |=> (state_q == S_IDLE))
    else $error("scan did not return to idle after full rotation");

  a_scan_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && out_valid_q) |-> out_ready_i)
    else $error("result register overwritten before transfer");

endmodule

### hw/rtl/positional_array_insert_delete_search_core.sv
// Positional list core: a chain of entry cells plus its sequencer.
// Insert and delete finish on the input transfer and give one result each. Search and dump
// rotate the whole cell ring once after the input transfer, and no new input transfer is
// taken until the rotation is done; an empty dump finishes on its input transfer. Every
// request also waits while a result sits on out_ready_i, and a scan stalls while its result
// waits; the ring length, CAPACITY, sets how long a scan lasts. The list is packed and
// ordered; a search reports the lowest matching index, a dump emits one entry per
// result with last set on the final one, and an empty dump gives one result with
// status empty. Depends on paids_pkg, paids_cell and paids_ctrl.
module positional_array_insert_delete_search_core import paids_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [TYPE_W-1:0]        req_type_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [INDEX_W-1:0]       index_o,
  output logic signed [DATA_W-1:0] item_value_o,
  output logic [FILL_W-1:0]        fill_count_o,
  output logic                     last_o
);

  cell_ctl_t                ctl;
  logic [CMP_W-1:0]         pos;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];

  paids_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .index_o      (index_o),
    .item_value_o (item_value_o),
    .fill_count_o (fill_count_o),
    .last_o       (last_o),
    .head_i       (cell_data[0]),
    .ctl_o        (ctl),
    .pos_o        (pos)
  );

  // ring: cell i shifts up from i-1, shifts down or rotates from i+1
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_data;
    logic signed [DATA_W-1:0] next_data;

    if (i == 0) begin : g_first
      assign prev_data = '0;
    end else begin : g_mid
      assign prev_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_data = cell_data[0];
    end else begin : g_inner
      assign next_data = cell_data[i+1];
    end

    paids_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .cell_idx_i (CMP_W'(i)),
      .pos_i      (pos),
      .value_i    (value_i),
      .prev_i     (prev_data),
      .next_i     (next_data),
      .data_o     (cell_data[i])
    );
  end

endmodule

### test/tb_positional_array_insert_delete_search_core.sv
`timescale 1ns / 1ps
// Testbench for the positional list core: insert, delete, search and dump.
// Predicts every result from its own copy of the list and checks results in order.
// Depends on paids_pkg and positional_array_insert_delete_search_core.
module tb_positional_array_insert_delete_search_core;
  import paids_pkg::*;

  localparam int RX_HOLD_CYCLES = 400;

  typedef struct {
    status_e                  status;
    logic [INDEX_W-1:0]       index;
    logic signed [DATA_W-1:0] item_value;
    logic [FILL_W-1:0]        fill_count;
    logic                     last;
  } list_result_t;

  class list_scoreboard;
    logic signed [DATA_W-1:0] cells [CAPACITY];
    int                       fill;
    list_result_t             pending[$];
    int                       errors;

    function new();
      fill   = 0;
      errors = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function void queue_result(status_e st, int idx, logic signed [DATA_W-1:0] v, logic lst);
      list_result_t r;
      r.status     = st;
      r.index      = idx[INDEX_W-1:0];
      r.item_value = v;
      r.fill_count = fill[FILL_W-1:0];
      r.last       = lst;
      pending.push_back(r);
    endfunction

    // applies one accepted request to the list copy and queues its results
    function void note_request(req_e req, logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] val);
      int p;
      int i;
      int hit;
      int n;
      p = int'(pos);
      case (req)
        REQ_INSERT: begin
          if (p > fill || fill >= CAPACITY) begin
            queue_result(ST_INVALID, 0, '0, 1'b1);
          end else begin
            for (i = fill; i > p; i--) cells[i] = cells[i-1];
            cells[p] = val;
            fill++;
            queue_result(ST_OK, 0, '0, 1'b1);
          end
        end
        REQ_DELETE: begin
          if (p >= fill) begin
            queue_result(ST_INVALID, 0, '0, 1'b1);
          end else begin
            for (i = p; i + 1 < fill; i++) cells[i] = cells[i+1];
            fill--;
            queue_result(ST_OK, 0, '0, 1'b1);
          end
        end
        REQ_SEARCH: begin
          hit = -1;
          for (i = 0; i < fill; i++) begin
            if (hit < 0 && cells[i] == val) hit = i;
          end
          if (hit < 0) queue_result(ST_NOT_FOUND, 0, '0, 1'b1);
          else queue_result(ST_OK, hit, '0, 1'b1);
        end
        default: begin
          if (fill == 0) begin
            queue_result(ST_EMPTY, 0, '0, 1'b1);
          end else begin
            n = (fill > MAX_OUT) ? MAX_OUT : fill;
            for (i = 0; i < n; i++) queue_result(ST_OK, i, cells[i], i == n - 1);
          end
        end
      endcase
    endfunction

    function void compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [INDEX_W-1:0] idx,
                               logic signed [DATA_W-1:0] v, logic [FILL_W-1:0] fc, logic lst);
      list_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d index %0d value %0d",
                 $time, st, idx, v);
        errors++;
        return;
      end
      e = pending.pop_front();
      compare_field("status", longint'(e.status), longint'(st));
      compare_field("index", longint'(e.index), longint'(idx));
      compare_field("item_value", longint'(e.item_value), longint'(v));
      compare_field("fill_count", longint'(e.fill_count), longint'(fc));
      compare_field("last", longint'(e.last), longint'(lst));
    endfunction
  endclass

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_ready_o;
  logic [TYPE_W-1:0]        req_type_i   = '0;
  logic [POS_W-1:0]         position_i   = '0;
  logic signed [DATA_W-1:0] value_i      = '0;
  logic                     out_valid_o;
  logic                     out_ready_i  = 1'b0;
  logic [STATUS_W-1:0]      status_o;
  logic [INDEX_W-1:0]       index_o;
  logic signed [DATA_W-1:0] item_value_o;
  logic [FILL_W-1:0]        fill_count_o;
  logic                     last_o;

  int  tx_idle_pct = 12;
  int  rx_idle_pct = 46;
  bit  rx_hold_req = 1'b0;

  list_scoreboard sb = new();

  positional_array_insert_delete_search_core dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(status_o, index_o, item_value_o, fill_count_o, last_o);
  end

  task automatic send_request(req_e req, logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req, pos, val);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
  endtask

  // small pool makes duplicates likely, so lowest-index search gets exercised
  function automatic logic signed [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return $signed(DATA_W'($urandom_range(0, 7))) - 4;
    if (roll < 30) return (roll & 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    return $urandom;
  endfunction

  task automatic random_request(int ins_w, int del_w, int srch_w);
    int                       roll;
    int                       f;
    req_e                     req;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    f    = sb.fill;
    roll = $urandom_range(0, 99);
    if (roll < ins_w) req = REQ_INSERT;
    else if (roll < ins_w + del_w) req = REQ_DELETE;
    else if (roll < ins_w + del_w + srch_w) req = REQ_SEARCH;
    else req = REQ_DUMP;
    // mostly legal positions, now and then anything the field holds
    if ($urandom_range(0, 99) < 15) pos = POS_W'($urandom_range(0, 127));
    else if (req == REQ_DELETE && f > 0) pos = POS_W'($urandom_range(0, f - 1));
    else pos = POS_W'($urandom_range(0, f));
    if (req == REQ_SEARCH && f > 0 && $urandom_range(0, 99) < 60)
      val = sb.cells[$urandom_range(0, f - 1)];
    else
      val = pick_value();
    send_request(req, pos, val);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list cases, extremes, ends and middle of the list
    send_request(REQ_DUMP,   0, '0);
    send_request(REQ_SEARCH, 0, 32'sh0000_1234);
    send_request(REQ_DELETE, 0, '0);
    send_request(REQ_INSERT, 1, 32'sd9);
    send_request(REQ_INSERT, 0, 32'sh8000_0000);
    send_request(REQ_INSERT, 1, 32'sh7fff_ffff);
    send_request(REQ_INSERT, 0, 32'sd0);
    send_request(REQ_INSERT, 1, -32'sd1);
    send_request(REQ_INSERT, 2, 32'sh7fff_ffff);
    send_request(REQ_INSERT, 127, 32'sd5);
    send_request(REQ_INSERT, 6, 32'sd5);
    send_request(REQ_SEARCH, 0, 32'sh7fff_ffff);
    send_request(REQ_SEARCH, 127, 32'sh8000_0000);
    send_request(REQ_SEARCH, 0, 32'sd12345);
    send_request(REQ_DUMP,   0, '0);
    send_request(REQ_DELETE, 127, '0);
    send_request(REQ_DELETE, 5, '0);
    send_request(REQ_DELETE, 4, '0);
    send_request(REQ_DELETE, 0, '0);
    send_request(REQ_DELETE, 1, '0);
    send_request(REQ_INSERT, 2, 32'sh5555_5555);
    send_request(REQ_INSERT, 3, 32'shaaaa_aaaa);
    send_request(REQ_SEARCH, 0, -32'sd1);
    send_request(REQ_DUMP,   0, '0);

    // mixed traffic behind a long receiver hold-off, so the input backs up
    rx_hold_req = 1'b1;
    repeat (20) random_request(45, 20, 25);
    wait_drained();

    // swap idle rates, fill the list to capacity and poke at the full list
    tx_idle_pct = 46;
    rx_idle_pct = 12;
    while (sb.fill < CAPACITY)
      send_request(REQ_INSERT, POS_W'($urandom_range(0, sb.fill)), pick_value());
    send_request(REQ_INSERT, POS_W'($urandom_range(0, CAPACITY - 1)), pick_value());
    send_request(REQ_INSERT, POS_W'(CAPACITY), pick_value());
    send_request(REQ_DELETE, POS_W'(CAPACITY), '0);
    send_request(REQ_SEARCH, 0, sb.cells[CAPACITY-1]);
    send_request(REQ_DUMP, 0, '0);
    repeat (8) random_request(10, 60, 20);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (10) random_request(35, 30, 25);
    wait_drained();

    repeat (2 * CAPACITY) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
